@@ design/tce_pkg.sv @@
// text console engine package: operation codes, command, cell and result types
// no dependencies
`default_nettype none

package tce_pkg;

    localparam int IDX_W   = 11;
    localparam int CUR_W   = 11;
    localparam int SYM_W   = 8;
    localparam int COL_W   = 32;
    localparam int CFG_W   = 32;

    // input modes
    localparam logic [2:0] MODE_PUT   = 3'd0;
    localparam logic [2:0] MODE_BS    = 3'd1;
    localparam logic [2:0] MODE_LEFT  = 3'd2;
    localparam logic [2:0] MODE_RIGHT = 3'd3;
    localparam logic [2:0] MODE_UP    = 3'd4;
    localparam logic [2:0] MODE_DOWN  = 3'd5;
    localparam logic [2:0] MODE_CLEAR = 3'd6;
    localparam logic [2:0] MODE_READ  = 3'd7;

    // control characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_BLANK = 8'h20;
    localparam logic [1:0] TAB_MASK = 2'b11;

    // configuration registers
    localparam logic CFG_TEXT  = 1'b0;
    localparam logic CFG_PAPER = 1'b1;
    localparam logic [31:0] TEXT_RESET  = 32'hFFFF_FFFF;
    localparam logic [31:0] PAPER_RESET = 32'h0000_0000;

    typedef enum logic [3:0] {
        OP_PUT, OP_CR, OP_LF, OP_TAB, OP_BS, OP_LEFT, OP_RIGHT,
        OP_UP, OP_DOWN, OP_CLEAR, OP_READ
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [SYM_W-1:0] code;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic [COL_W-1:0] fore;
        logic [COL_W-1:0] back;
    } t_cell;

    typedef struct packed {
        logic [CUR_W-1:0] cursor;
        t_cell            entry;
    } t_res;

    // back end to front end status
    typedef struct packed {
        logic take;
        logic init;
    } t_bk_ctl;

endpackage

`default_nettype wire

@@ design/tce_front.sv @@
// front end: classifies incoming transactions and holds them in a two-entry queue
// depends on tce_pkg
`default_nettype none

module tce_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    output logic                    o_full,
    input  wire logic [2:0]         i_mode,
    input  wire logic [7:0]         i_char_code,
    input  wire logic [10:0]        i_cell_index,
    input  wire tce_pkg::t_bk_ctl   i_ctl,
    output logic                    o_cmd_valid,
    output tce_pkg::t_cmd           o_cmd
);

    tce_pkg::t_cmd r_q0, r_q1, n_q0, n_q1;
    logic [1:0]    r_cnt, n_cnt;
    tce_pkg::t_cmd w_cls;
    logic          w_push, w_pop;

    // classify mode and byte into an operation
    always_comb begin
        w_cls.code = i_char_code;
        w_cls.idx  = i_cell_index;
        case (i_mode)
            tce_pkg::MODE_PUT: begin
                if (i_char_code == tce_pkg::CH_CR)       w_cls.op = tce_pkg::OP_CR;
                else if (i_char_code == tce_pkg::CH_LF)  w_cls.op = tce_pkg::OP_LF;
                else if (i_char_code == tce_pkg::CH_TAB) w_cls.op = tce_pkg::OP_TAB;
                else                                     w_cls.op = tce_pkg::OP_PUT;
            end
            tce_pkg::MODE_BS:    w_cls.op = tce_pkg::OP_BS;
            tce_pkg::MODE_LEFT:  w_cls.op = tce_pkg::OP_LEFT;
            tce_pkg::MODE_RIGHT: w_cls.op = tce_pkg::OP_RIGHT;
            tce_pkg::MODE_UP:    w_cls.op = tce_pkg::OP_UP;
            tce_pkg::MODE_DOWN:  w_cls.op = tce_pkg::OP_DOWN;
            tce_pkg::MODE_CLEAR: w_cls.op = tce_pkg::OP_CLEAR;
            default:             w_cls.op = tce_pkg::OP_READ;
        endcase
    end

    assign o_full      = (r_cnt == 2'd2) || i_ctl.init;
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_ctl.take && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q0;

    // queue update
    always_comb begin
        n_q0  = r_q0;
        n_q1  = r_q1;
        n_cnt = r_cnt;
        if (w_pop) begin
            n_q0  = r_q1;
            n_cnt = n_cnt - 2'd1;
        end
        if (w_push) begin
            if (n_cnt == 2'd0) n_q0 = w_cls;
            else               n_q1 = w_cls;
            n_cnt = n_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

endmodule

`default_nettype wire

@@ design/tce_resq.sv @@
// result queue: two entries between the back end and the result ports
// depends on tce_pkg
`default_nettype none

module tce_resq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire tce_pkg::t_res  i_res,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output tce_pkg::t_res       o_head
);

    tce_pkg::t_res r_e0, r_e1, n_e0, n_e1;
    logic [1:0]    r_cnt, n_cnt;
    logic          w_push, w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_e0;
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // queue update
    always_comb begin
        n_e0  = r_e0;
        n_e1  = r_e1;
        n_cnt = r_cnt;
        if (w_pop) begin
            n_e0  = r_e1;
            n_cnt = n_cnt - 2'd1;
        end
        if (w_push) begin
            if (n_cnt == 2'd0) n_e0 = i_res;
            else               n_e1 = i_res;
            n_cnt = n_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_e0 <= n_e0;
        r_e1 <= n_e1;
    end

endmodule

`default_nettype wire

@@ design/tce_back.sv @@
// back end: cell memory with a rotating top row and the operation sequencer
// depends on tce_pkg
`default_nettype none

module tce_back #(
    parameter int COLUMNS = 64,
    parameter int ROWS    = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmd_valid,
    input  wire tce_pkg::t_cmd      i_cmd,
    output tce_pkg::t_bk_ctl        o_ctl,
    input  wire logic [31:0]        i_text_colour,
    input  wire logic [31:0]        i_paper_colour,
    input  wire logic               i_res_full,
    output logic                    o_res_push,
    output tce_pkg::t_res           o_res
);

    localparam int TOTAL = COLUMNS * ROWS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int AW    = $clog2(TOTAL);
    localparam int IW    = tce_pkg::IDX_W;
    localparam int NW    = $clog2(IW);
    localparam int RS    = IW + CW;
    localparam logic [IW+1:0] RCP = (IW+2)'(((1 << RS) + COLUMNS - 1) / COLUMNS);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_EXEC    = 11'b000_0000_0010,
        S_SCROLL  = 11'b000_0000_0100,
        S_BS_RD   = 11'b000_0000_1000,
        S_BS_WR   = 11'b000_0001_0000,
        S_BS_END  = 11'b000_0010_0000,
        S_CLEAR   = 11'b000_0100_0000,
        S_DIV     = 11'b000_1000_0000,
        S_RD      = 11'b001_0000_0000,
        S_RD_WAIT = 11'b010_0000_0000,
        S_DONE    = 11'b100_0000_0000
    } t_state;

    t_state          r_state, n_state;
    logic            r_init, n_init;
    tce_pkg::t_cmd   r_cmd, n_cmd;
    logic [RW-1:0]   r_row, n_row, r_top, n_top;
    logic [CW-1:0]   r_col, n_col, r_k, n_k, r_rem, n_rem;
    logic [AW-1:0]   r_lin, n_lin;
    logic [IW-1:0]   r_dv, n_dv, r_qt, n_qt;
    logic [NW-1:0]   r_dcnt, n_dcnt;
    tce_pkg::t_cell  r_rd, n_rd;

    tce_pkg::t_cell  r_mem [TOTAL];
    tce_pkg::t_cell  r_rdata;
    logic            w_we;
    logic [AW-1:0]   w_waddr, w_raddr;
    tce_pkg::t_cell  w_wdata, w_blank;

    logic [RW-1:0]   a_row;
    logic [CW-1:0]   a_col;
    logic [RW:0]     a_sum;
    logic [RW-1:0]   a_phys;
    logic [AW-1:0]   a_addr;

    logic            w_adv, w_down, w_done;
    logic [2*IW+1:0] w_prod;

    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);

    // blank cell colours, reset values during the power-up pass
    always_comb begin
        w_blank.sym  = tce_pkg::CH_BLANK;
        w_blank.fore = r_init ? tce_pkg::TEXT_RESET  : i_text_colour;
        w_blank.back = r_init ? tce_pkg::PAPER_RESET : i_paper_colour;
    end

    // address select by state
    always_comb begin
        a_row = r_row;
        a_col = r_col;
        case (r_state)
            S_SCROLL: begin a_row = ROW_LAST; a_col = r_k; end
            S_BS_RD:  a_col = r_k;
            S_BS_WR:  a_col = r_k - CW'(1);
            S_BS_END: a_col = COL_LAST;
            S_RD: begin a_row = r_qt[RW-1:0]; a_col = r_rem; end
            default: ;
        endcase
    end

    // logical row to physical address through the rotating top row
    always_comb begin
        a_sum  = {1'b0, a_row} + {1'b0, r_top};
        a_phys = (a_sum >= (RW+1)'(ROWS)) ? RW'(a_sum - (RW+1)'(ROWS)) : a_sum[RW-1:0];
        a_addr = AW'(a_phys) * AW'(COLUMNS) + AW'(a_col);
    end

    // cell index to row by reciprocal multiplication
    assign w_prod = (2*IW+2)'(r_dv) * (2*IW+2)'(RCP);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_init  = r_init;
        n_cmd   = r_cmd;
        n_row   = r_row;
        n_col   = r_col;
        n_top   = r_top;
        n_k     = r_k;
        n_lin   = r_lin;
        n_dv    = r_dv;
        n_qt    = r_qt;
        n_rem   = r_rem;
        n_dcnt  = r_dcnt;
        n_rd    = r_rd;
        w_we    = 1'b0;
        w_waddr = a_addr;
        w_wdata = w_blank;
        w_raddr = a_addr;
        w_adv   = 1'b0;
        w_down  = 1'b0;
        w_done  = 1'b1;
        o_ctl.take = 1'b0;
        o_ctl.init = r_init;
        o_res_push = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && !r_init) begin
                    o_ctl.take = 1'b1;
                    n_cmd   = i_cmd;
                    n_rd    = '0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd.op)
                    tce_pkg::OP_PUT: begin
                        w_we = 1'b1;
                        w_wdata.sym = r_cmd.code;
                        w_adv = 1'b1;
                    end
                    tce_pkg::OP_TAB: begin
                        if ((r_col[1:0] & tce_pkg::TAB_MASK) != 2'b00) begin
                            w_we   = 1'b1;
                            w_adv  = 1'b1;
                            w_done = 1'b0;
                        end
                    end
                    tce_pkg::OP_CR: n_col = '0;
                    tce_pkg::OP_LF: begin
                        n_col  = '0;
                        w_down = 1'b1;
                    end
                    tce_pkg::OP_BS: begin
                        if (r_col != '0) begin
                            n_col   = r_col - CW'(1);
                            n_k     = r_col;
                            w_done  = 1'b0;
                            n_state = S_BS_RD;
                        end else if (r_row != '0) begin
                            n_row   = r_row - RW'(1);
                            n_col   = COL_LAST;
                            w_done  = 1'b0;
                            n_state = S_BS_END;
                        end
                    end
                    tce_pkg::OP_LEFT: begin
                        if (r_col != '0) begin
                            n_col = r_col - CW'(1);
                        end else if (r_row != '0) begin
                            n_row = r_row - RW'(1);
                            n_col = COL_LAST;
                        end
                    end
                    tce_pkg::OP_RIGHT: w_adv = 1'b1;
                    tce_pkg::OP_UP: begin
                        if (r_row != '0) n_row = r_row - RW'(1);
                    end
                    tce_pkg::OP_DOWN: w_down = 1'b1;
                    tce_pkg::OP_CLEAR: begin
                        n_row   = '0;
                        n_col   = '0;
                        n_top   = '0;
                        n_lin   = '0;
                        w_done  = 1'b0;
                        n_state = S_CLEAR;
                    end
                    default: begin
                        if (32'(r_cmd.idx) < TOTAL) begin
                            n_dv    = r_cmd.idx;
                            n_qt    = '0;
                            n_rem   = '0;
                            n_dcnt  = NW'(1);
                            w_done  = 1'b0;
                            n_state = S_DIV;
                        end
                    end
                endcase
                // cursor advance wraps into the next row
                if (w_adv) begin
                    if (r_col == COL_LAST) begin
                        n_col  = '0;
                        w_down = 1'b1;
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end
                // next row, or scroll on the bottom row
                if (w_down && r_row != ROW_LAST) begin
                    n_row = r_row + RW'(1);
                end
                if (w_down && r_row == ROW_LAST) begin
                    n_top   = (r_top == ROW_LAST) ? '0 : r_top + RW'(1);
                    n_k     = '0;
                    n_state = S_SCROLL;
                end else if (w_done) begin
                    n_state = S_DONE;
                end
            end
            S_SCROLL: begin
                w_we = 1'b1;
                n_k  = r_k + CW'(1);
                if (r_k == COL_LAST) n_state = S_DONE;
            end
            S_BS_RD: n_state = S_BS_WR;
            S_BS_WR: begin
                w_we    = 1'b1;
                w_wdata = r_rdata;
                if (r_k == COL_LAST) begin
                    n_state = S_BS_END;
                end else begin
                    n_k     = r_k + CW'(1);
                    n_state = S_BS_RD;
                end
            end
            S_BS_END: begin
                w_we    = 1'b1;
                n_state = S_DONE;
            end
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_lin;
                n_lin   = r_lin + AW'(1);
                if (32'(r_lin) == TOTAL - 1) begin
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_DONE;
                end
            end
            // the row first, then the column
            S_DIV: begin
                if (r_dcnt != '0) begin
                    n_qt   = IW'(w_prod >> RS);
                    n_dcnt = '0;
                end else begin
                    n_rem   = CW'(32'(r_dv) - 32'(r_qt) * COLUMNS);
                    n_state = S_RD;
                end
            end
            S_RD: n_state = S_RD_WAIT;
            S_RD_WAIT: begin
                n_rd    = r_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result: linear cursor and read cell
    assign o_res.cursor = tce_pkg::CUR_W'(AW'(r_row) * AW'(COLUMNS) + AW'(r_col));
    assign o_res.entry  = r_rd;

    // cell memory
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr];
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_init  <= 1'b1;
            r_row   <= '0;
            r_col   <= '0;
            r_top   <= '0;
            r_lin   <= '0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_row   <= n_row;
            r_col   <= n_col;
            r_top   <= n_top;
            r_lin   <= n_lin;
        end
        r_cmd  <= n_cmd;
        r_k    <= n_k;
        r_dv   <= n_dv;
        r_qt   <= n_qt;
        r_rem  <= n_rem;
        r_dcnt <= n_dcnt;
        r_rd   <= n_rd;
    end

    // checks
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_we)
        else $error("cell write while idle");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_row) < ROWS) && (32'(r_col) < COLUMNS))
        else $error("cursor outside grid");

    a_take_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.take |=> (r_state == S_EXEC))
        else $error("taken command not executed");

    a_no_take_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !o_ctl.take)
        else $error("command taken during power-up clear");

endmodule

`default_nettype wire

@@ design/text_console_engine.sv @@
// An accepted transaction passes the execute state and waits in the done state until the
// result queue has room; a scroll adds a pass that blanks the bottom row, and a tab writes
// blanks up to a multiple of four columns; backspace shifts the row tail left, a cell read
// divides the index into row and column before reading, and clear blanks every cell.
// The sequencer works on one transaction at a time. Reset: synchronous; afterwards a clearing
// pass blanks the memory, during which full stays high. Config writes are taken at all times.
`default_nettype none

module text_console_engine #(
    parameter int COLUMNS = 64,
    parameter int ROWS    = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    output logic              o_full,
    input  wire logic [2:0]   i_mode,
    input  wire logic [7:0]   i_char_code,
    input  wire logic [10:0]  i_cell_index,
    output logic              o_empty,
    input  wire logic         i_pop,
    output logic [10:0]       o_cursor_at,
    output logic [7:0]        o_cell_symbol,
    output logic [31:0]       o_cell_fore,
    output logic [31:0]       o_cell_back,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_idx,
    input  wire logic [31:0]  i_cfg_data
);

    logic [31:0]       r_text_colour, r_paper_colour;
    logic              w_cmd_valid, w_res_push, w_res_full;
    tce_pkg::t_cmd     w_cmd;
    tce_pkg::t_bk_ctl  w_ctl;
    tce_pkg::t_res     w_res, w_head;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_colour  <= tce_pkg::TEXT_RESET;
            r_paper_colour <= tce_pkg::PAPER_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == tce_pkg::CFG_TEXT)  r_text_colour  <= i_cfg_data;
            if (i_cfg_idx == tce_pkg::CFG_PAPER) r_paper_colour <= i_cfg_data;
        end
    end

    tce_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_mode       (i_mode),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_ctl        (w_ctl),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd)
    );

    tce_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (w_cmd_valid),
        .i_cmd          (w_cmd),
        .o_ctl          (w_ctl),
        .i_text_colour  (r_text_colour),
        .i_paper_colour (r_paper_colour),
        .i_res_full     (w_res_full),
        .o_res_push     (w_res_push),
        .o_res          (w_res)
    );

    tce_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res),
        .o_full  (w_res_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_head  (w_head)
    );

    // result ports
    assign o_cursor_at   = w_head.cursor;
    assign o_cell_symbol = w_head.entry.sym;
    assign o_cell_fore   = w_head.entry.fore;
    assign o_cell_back   = w_head.entry.back;

endmodule

`default_nettype wire
